FILE: sv/cep_pkg.sv
`default_nettype none
package cep_pkg;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TIME_STEP = 2'd0,
      REG_INIT_LEN  = 2'd1
   } csr_reg_type;

   localparam logic [30:0] DT_RESET = 31'd328;
   localparam logic [30:0] IL_RESET = 31'd131072;
   localparam logic [30:0] MASK31   = 31'h7fff_ffff;
   localparam logic [47:0] WCAP     = 48'hffff_ffff_ffff;
   localparam logic [47:0] Q_PI     = 48'd205887;
   // reciprocals: x/3 (x < 2^33) shift 35, x/3 (x < 2^44) shift 46, x/5 (x < 2^47) shift 50
   localparam logic [47:0] M3A      = 48'd11453246123;
   localparam logic [47:0] M3B      = 48'd23456248059222;
   localparam logic [47:0] M5       = 48'd225179981368525;
   localparam logic [31:0] SMAX     = 32'h7fff_ffff;
   localparam logic [31:0] SMIN     = 32'h8000_0000;

   typedef struct packed {
      logic [47:0] ll;
      logic [47:0] lh;
      logic [47:0] hl;
      logic [47:0] hh;
   } pp_type;

   typedef struct packed {
      logic [30:0]      cyc;
      logic [30:0]      r;
      logic [45:0]      r2;
      logic [31:0]      t43;
      logic [47:0]      p;
      logic [44:0]      r2d5;
      logic [3:0][31:0] val;
      logic [3:0][31:0] frc;
   } ctx_a_type;

   typedef struct packed {
      logic [30:0]      len;
      logic             fault;
      logic [3:0]       neg;
      logic [3:0][31:0] val;
   } ctx_b_type;

   typedef struct packed {
      logic [30:0]      len;
      logic             fault;
      logic [3:0][31:0] v;
   } rsp_type;

   function automatic pp_type pp_make(logic [47:0] a, logic [47:0] b);
      pp_type p;
      p.ll = a[23:0] * b[23:0];
      p.lh = a[23:0] * b[47:24];
      p.hl = a[47:24] * b[23:0];
      p.hh = a[47:24] * b[47:24];
      return p;
   endfunction

   function automatic logic [95:0] pp_sum(pp_type p);
      return {48'd0, p.ll} + ({48'd0, p.lh} << 24) + ({48'd0, p.hl} << 24) + {p.hh, 48'd0};
   endfunction

   // product >> 16, capped
   function automatic logic [47:0] qcap(logic [95:0] x);
      return (x[95:64] != 32'd0) ? WCAP : x[63:16];
   endfunction

   function automatic logic [47:0] sadd48(logic [48:0] s);
      return s[48] ? WCAP : s[47:0];
   endfunction

   function automatic logic [31:0] mag32(logic [31:0] x);
      return x[31] ? (~x + 32'd1) : x;
   endfunction

endpackage
`default_nettype wire

FILE: sv/capsule_euler_position_update.sv
// Throughput: one item per cycle while the skid is empty; req_ready is low otherwise.
// Two 1-bit-per-stage dividers (length, 32 stages; Euler step, 33 stages) and
//   12 arithmetic stages set the depth.
// A one-entry skid behind the output register keeps input open while a result waits.
// Reset: synchronous; clears all valid bits, time_step to 328, initial_length to 2.0.
`default_nettype none
module capsule_euler_position_update #(
   parameter int SPACE_DIMS = 2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [30:0]                    req_cell_age,
   input  wire logic [30:0]                    req_cycle_duration,
   input  wire logic [30:0]                    req_radius,
   input  wire logic signed [31:0]             req_pos_x,
   input  wire logic signed [31:0]             req_pos_y,
   input  wire logic signed [31:0]             req_pos_z,
   input  wire logic signed [31:0]             req_force_x,
   input  wire logic signed [31:0]             req_force_y,
   input  wire logic signed [31:0]             req_force_z,
   input  wire logic signed [31:0]             req_angle,
   input  wire logic signed [31:0]             req_torque,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [30:0]                         rsp_new_length,
   output logic signed [31:0]                  rsp_new_pos_x,
   output logic signed [31:0]                  rsp_new_pos_y,
   output logic signed [31:0]                  rsp_new_pos_z,
   output logic signed [31:0]                  rsp_new_angle,
   output logic                                rsp_div_fault,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [cep_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [30:0]                    csr_data
);

   import cep_pkg::*;

   logic [30:0] dt_ff, il_ff;
   logic        en;
   logic        out_v_ff, sk_v_ff;
   rsp_type     out_ff, sk_ff, fin_in;
   logic        fin_v;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff <= DT_RESET;
         il_ff <= IL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TIME_STEP: dt_ff <= csr_data;
            REG_INIT_LEN:  il_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign en        = !sk_v_ff;
   assign req_ready = en;

   // stage 1
   logic        v1_ff;
   ctx_a_type   c1_in, c1_ff;
   logic [32:0] growth_in;
   logic [63:0] ga1_in, ga1_ff;
   logic [61:0] rr_in;
   pp_type      pt1_ff;

   assign growth_in = {2'b00, il_ff} + {1'b0, req_radius, 1'b0};
   assign ga1_in    = growth_in * req_cell_age;
   assign rr_in     = req_radius * req_radius;

   always_comb begin
      c1_in        = '0;
      c1_in.cyc    = req_cycle_duration;
      c1_in.r      = req_radius;
      c1_in.r2     = rr_in[61:16];
      c1_in.val[0] = req_pos_x;
      c1_in.val[1] = req_pos_y;
      c1_in.val[2] = req_pos_z;
      c1_in.val[3] = req_angle;
      c1_in.frc[0] = req_force_x;
      c1_in.frc[1] = req_force_y;
      c1_in.frc[2] = req_force_z;
      c1_in.frc[3] = req_torque;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff  <= c1_in;
         ga1_ff <= ga1_in;
         pt1_ff <= pp_make(48'({req_radius, 2'b00}), M3A);
      end
   end

   // stage 2
   logic        v2_ff;
   ctx_a_type   c2_in, c2_ff;
   logic [95:0] st1_in;
   logic [63:0] ga2_ff;
   pp_type      pp_p2_ff, pp_r5_2_ff;

   assign st1_in = pp_sum(pt1_ff);

   always_comb begin
      c2_in     = c1_ff;
      c2_in.t43 = st1_in[66:35];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff      <= c2_in;
         ga2_ff     <= ga1_ff;
         pp_p2_ff   <= pp_make(Q_PI, 48'(c1_ff.r2));
         pp_r5_2_ff <= pp_make(48'({c1_ff.r2, 1'b0}), M5);
      end
   end

   // stage 3
   logic        v3_ff;
   ctx_a_type   c3_in, c3_ff;
   logic [95:0] sp_in, sr5_in;
   logic [63:0] ga3_ff;

   assign sp_in  = pp_sum(pp_p2_ff);
   assign sr5_in = pp_sum(pp_r5_2_ff);

   always_comb begin
      c3_in      = c2_ff;
      c3_in.p    = qcap(sp_in);
      c3_in.r2d5 = sr5_in[94:50];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c3_ff  <= c3_in;
         ga3_ff <= ga2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // length division
   logic [63:0]                  ld_dvd [1];
   logic [30:0]                  ld_dvs [1];
   logic [30:0]                  ld_quo [1];
   logic                         ld_ovf [1];
   logic                         ld_v;
   logic [$bits(ctx_a_type)-1:0] ld_pay;

   assign ld_dvd[0] = ga3_ff;
   assign ld_dvs[0] = c3_ff.cyc;

   cep_div #(
      .LANES (1),
      .DW    (64),
      .VW    (31),
      .QW    (31),
      .PW    ($bits(ctx_a_type))
   ) u_len_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_dvd    (ld_dvd),
      .in_dvs    (ld_dvs),
      .in_pay    (c3_ff),
      .out_valid (ld_v),
      .out_quo   (ld_quo),
      .out_ovf   (ld_ovf),
      .out_pay   (ld_pay)
   );

   // stage 4: length
   ctx_a_type   lp;
   logic [31:0] lsum_in;
   logic [30:0] len4_in;
   ctx_a_type   c4_ff, c5_ff, c6_ff, c7_ff, c8_ff, c9_ff, c10_ff, c11_ff;
   logic [30:0] len4_ff, len5_ff, len6_ff, len7_ff, len8_ff, len9_ff, len10_ff, len11_ff;
   logic [8:0]  vp_ff;

   assign lp      = ld_pay;
   assign lsum_in = {1'b0, il_ff} + {1'b0, ld_quo[0]};

   always_comb begin
      if (lp.cyc == 31'd0) begin
         len4_in = '0;
      end else if (ld_ovf[0] || lsum_in[31]) begin
         len4_in = MASK31;
      end else begin
         len4_in = lsum_in[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= '0;
      end else if (en) begin
         vp_ff <= {vp_ff[7:0], ld_v};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c4_ff    <= lp;
         len4_ff  <= len4_in;
         c5_ff    <= c4_ff;
         len5_ff  <= len4_ff;
         c6_ff    <= c5_ff;
         len6_ff  <= len5_ff;
         c7_ff    <= c6_ff;
         len7_ff  <= len6_ff;
         c8_ff    <= c7_ff;
         len8_ff  <= len7_ff;
         c9_ff    <= c8_ff;
         len9_ff  <= len8_ff;
         c10_ff   <= c9_ff;
         len10_ff <= len9_ff;
         c11_ff   <= c10_ff;
         len11_ff <= len10_ff;
      end
   end

   // stage 5: L^2, L*r, mass partials
   logic [61:0] ll_in, lr_in;
   logic [32:0] lt_in;
   logic [45:0] l2_5_ff, l2_6_ff, l2_7_ff, lr5_ff;
   pp_type      ppm5_ff;

   assign ll_in = len4_ff * len4_ff;
   assign lr_in = len4_ff * c4_ff.r;
   assign lt_in = {2'b00, len4_ff} + {1'b0, c4_ff.t43};

   always_ff @(posedge clock) begin
      if (en) begin
         l2_5_ff <= ll_in[61:16];
         lr5_ff  <= lr_in[61:16];
         ppm5_ff <= pp_make(c4_ff.p, 48'(lt_in));
      end
   end

   // stage 6
   logic [95:0] sm_in;
   logic [47:0] lr3x_in;
   logic [44:0] lr3_6_ff, lr3_7_ff;
   logic [47:0] m6_ff, m7_ff, m8_ff, m9_ff, m10_ff, m11_ff;
   pp_type      ppl6_ff;

   assign sm_in   = pp_sum(ppm5_ff);
   assign lr3x_in = {2'b00, lr5_ff} + {1'b0, lr5_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (en) begin
         m6_ff    <= qcap(sm_in);
         lr3_6_ff <= lr3x_in[47:3];
         ppl6_ff  <= pp_make(48'(l2_5_ff[45:2]), M3B);
         l2_6_ff  <= l2_5_ff;
      end
   end

   // stage 7
   logic [95:0] sl_in;
   logic [42:0] l12_7_ff;

   assign sl_in = pp_sum(ppl6_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         l12_7_ff <= sl_in[88:46];
         l2_7_ff  <= l2_6_ff;
         lr3_7_ff <= lr3_6_ff;
         m7_ff    <= m6_ff;
      end
   end

   // stage 8: inertia brackets
   logic [44:0] a_in;
   logic [48:0] b_in;
   pp_type      ppi1_ff, ppi2_ff;

   assign a_in = {2'b00, l12_7_ff} + {1'b0, c7_ff.r2[45:2]};
   assign b_in = {4'd0, c7_ff.r2d5} + {5'd0, l2_7_ff[45:2]} + {4'd0, lr3_7_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         ppi1_ff <= pp_make(48'(len7_ff), 48'(a_in));
         ppi2_ff <= pp_make(48'(c7_ff.t43), sadd48(b_in));
         m8_ff   <= m7_ff;
      end
   end

   // stage 9
   logic [95:0] si1_in, si2_in;
   logic [47:0] in1_ff, in2_ff;

   assign si1_in = pp_sum(ppi1_ff);
   assign si2_in = pp_sum(ppi2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         in1_ff <= qcap(si1_in);
         in2_ff <= qcap(si2_in);
         m9_ff  <= m8_ff;
      end
   end

   // stage 10
   pp_type ppi_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ppi_ff <= pp_make(c9_ff.p, sadd48({1'b0, in1_ff} + {1'b0, in2_ff}));
         m10_ff <= m9_ff;
      end
   end

   // stage 11
   logic [95:0] sin_in;
   logic [47:0] inert_ff;

   assign sin_in = pp_sum(ppi_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         inert_ff <= qcap(sin_in);
         m11_ff   <= m10_ff;
      end
   end

   // stage 12: Euler dividends
   ctx_b_type   b12_in, b12_ff;
   logic [62:0] ed_dvd [4];
   logic [47:0] ed_dvs [4];

   always_comb begin
      b12_in.len   = len11_ff;
      b12_in.fault = (c11_ff.cyc == 31'd0) || (m11_ff == 48'd0) || (inert_ff == 48'd0);
      b12_in.val   = c11_ff.val;
      for (int i = 0; i < 4; i++) begin
         b12_in.neg[i] = c11_ff.frc[i][31];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b12_ff <= b12_in;
         for (int i = 0; i < 4; i++) begin
            ed_dvd[i] <= dt_ff * mag32(c11_ff.frc[i]);
            ed_dvs[i] <= (i < 3) ? m11_ff : inert_ff;
         end
      end
   end

   // Euler division
   logic [31:0]                  ed_quo [4];
   logic                         ed_ovf [4];
   logic                         ed_v;
   logic [$bits(ctx_b_type)-1:0] ed_pay;
   ctx_b_type                    ep;

   cep_div #(
      .LANES (4),
      .DW    (63),
      .VW    (48),
      .QW    (32),
      .PW    ($bits(ctx_b_type))
   ) u_step_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vp_ff[8]),
      .in_dvd    (ed_dvd),
      .in_dvs    (ed_dvs),
      .in_pay    (b12_ff),
      .out_valid (ed_v),
      .out_quo   (ed_quo),
      .out_ovf   (ed_ovf),
      .out_pay   (ed_pay)
   );

   assign ep = ed_pay;

   // final update and saturation
   always_comb begin
      fin_in.len   = ep.len;
      fin_in.fault = ep.fault;
      for (int i = 0; i < 4; i++) begin
         logic [33:0] s;
         s = ep.neg[i] ? ({{2{ep.val[i][31]}}, ep.val[i]} - {2'b00, ed_quo[i]})
                       : ({{2{ep.val[i][31]}}, ep.val[i]} + {2'b00, ed_quo[i]});
         if (ep.fault) begin
            fin_in.v[i] = ep.val[i];
         end else if (ed_ovf[i]) begin
            fin_in.v[i] = ep.neg[i] ? SMIN : SMAX;
         end else if (s[33:31] == 3'b000 || s[33:31] == 3'b111) begin
            fin_in.v[i] = s[31:0];
         end else begin
            fin_in.v[i] = s[33] ? SMIN : SMAX;
         end
         if (i < 3 && i >= SPACE_DIMS) begin
            fin_in.v[i] = '0;
         end
      end
   end

   assign fin_v = ed_v && en;

   // output register and skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         if (!out_v_ff || rsp_ready) begin
            if (sk_v_ff) begin
               out_v_ff <= 1'b1;
               sk_v_ff  <= 1'b0;
            end else begin
               out_v_ff <= fin_v;
            end
         end else if (fin_v) begin
            sk_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_ready) begin
         out_ff <= sk_v_ff ? sk_ff : fin_in;
      end
      if (out_v_ff && !rsp_ready && fin_v) begin
         sk_ff <= fin_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_new_length = out_ff.len;
   assign rsp_div_fault  = out_ff.fault;
   assign rsp_new_pos_x  = out_ff.v[0];
   assign rsp_new_pos_y  = out_ff.v[1];
   assign rsp_new_pos_z  = out_ff.v[2];
   assign rsp_new_angle  = out_ff.v[3];

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid holds an item while output register is empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(sk_v_ff) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid filled without a stalled output");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      $fell(sk_v_ff) |-> $past(rsp_ready))
      else $error("skid drained without output taken");

   a_unused_dims: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((SPACE_DIMS > 2 || rsp_new_pos_z == '0) &&
                     (SPACE_DIMS > 1 || rsp_new_pos_y == '0)))
      else $error("unused position component not zero");

endmodule
`default_nettype wire

FILE: sv/cep_div.sv
`default_nettype none
module cep_div #(
   parameter int LANES = 1,
   parameter int DW    = 64,
   parameter int VW    = 31,
   parameter int QW    = 31,
   parameter int PW    = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [DW-1:0] in_dvd [LANES],
   input  wire logic [VW-1:0] in_dvs [LANES],
   input  wire logic [PW-1:0] in_pay,
   output logic               out_valid,
   output logic [QW-1:0]      out_quo [LANES],
   output logic               out_ovf [LANES],
   output logic [PW-1:0]      out_pay
);

   localparam int HW = DW - QW;
   localparam int CW = (HW > VW) ? HW : VW;

   logic [QW:0]   v_ff;
   logic [PW-1:0] pay_ff [QW+1];
   logic [VW-1:0] rem_ff [QW+1][LANES];
   logic [VW-1:0] dvs_ff [QW+1][LANES];
   logic [QW-1:0] w_ff   [QW+1][LANES];
   logic          ovf_ff [QW+1][LANES];
   logic [CW-1:0] hi_c   [LANES];
   logic [CW-1:0] dvs_c  [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[QW-1:0], in_valid};
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         hi_c[l]  = CW'(in_dvd[l][DW-1:QW]);
         dvs_c[l] = CW'(in_dvs[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pay_ff[0] <= in_pay;
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= hi_c[l][VW-1:0];
            w_ff[0][l]   <= in_dvd[l][QW-1:0];
            dvs_ff[0][l] <= in_dvs[l];
            ovf_ff[0][l] <= (hi_c[l] >= dvs_c[l]);
         end
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [VW-1:0] rem_in [LANES];
      logic          bit_in [LANES];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            logic [VW:0] t;
            logic [VW:0] d;
            t = {rem_ff[k-1][l], w_ff[k-1][l][QW-1]};
            d = t - {1'b0, dvs_ff[k-1][l]};
            bit_in[l] = (t >= {1'b0, dvs_ff[k-1][l]});
            rem_in[l] = bit_in[l] ? d[VW-1:0] : t[VW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pay_ff[k] <= pay_ff[k-1];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l] <= rem_in[l];
               w_ff[k][l]   <= {w_ff[k-1][l][QW-2:0], bit_in[l]};
               dvs_ff[k][l] <= dvs_ff[k-1][l];
               ovf_ff[k][l] <= ovf_ff[k-1][l];
            end
         end
      end
   end

   assign out_valid = v_ff[QW];
   assign out_pay   = pay_ff[QW];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = w_ff[QW][l];
         out_ovf[l] = ovf_ff[QW][l];
      end
   end

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import cep_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LAST   = 2'd3;
   localparam logic [63:0] CAP48    = 64'hffff_ffff_ffff;
   localparam logic [63:0] STEP_CAP = 64'h2_0000_0000;
   localparam logic [63:0] PI_Q     = 64'd205887;
   localparam int    DRAIN_CYCLES   = 100;
   localparam int    WATCHDOG_LIMIT = 5000;
   localparam int    LONG_HOLD      = 400;

   typedef struct {
      logic [30:0] age, cyc, radius;
      logic [31:0] pos [3];
      logic [31:0] frc [3];
      logic [31:0] angle, torque;
   } cell_t;

   typedef struct {
      logic [30:0] length;
      logic [31:0] pos [3];
      logic [31:0] angle;
      logic        fault;
   } update_t;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic req_ready, rsp_valid, csr_ready, rsp_div_fault;
   logic [30:0] req_cell_age = 0, req_cycle_duration = 0, req_radius = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [31:0] req_force_x = 0, req_force_y = 0, req_force_z = 0;
   logic signed [31:0] req_angle = 0, req_torque = 0;
   logic [30:0] rsp_new_length;
   logic signed [31:0] rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z, rsp_new_angle;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [30:0] csr_data = 0;

   logic [63:0] step_dt   = 64'd328;
   logic [63:0] birth_len = 64'd131072;
   update_t     pending_updates [$];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   bit          fast_src = 0, fast_snk = 0, hold_request = 0;

   capsule_euler_position_update i_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> 16;
      return (p > CAP48) ? CAP48 : p[63:0];
   endfunction

   function automatic logic [63:0] fx_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > CAP48) ? CAP48 : s[63:0];
   endfunction

   function automatic logic [31:0] euler_step(logic [31:0] val, logic [31:0] f,
                                              logic [63:0] div);
      longint      v, s;
      logic [63:0] mag, q;
      v   = longint'(signed'(val));
      mag = f[31] ? (64'd0 - {{32{1'b1}}, f}) : {32'd0, f};
      q   = (step_dt * mag) / div;
      if (q > STEP_CAP) q = STEP_CAP;
      s = f[31] ? v - longint'(q) : v + longint'(q);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   function automatic update_t predict_update(cell_t c);
      update_t u;
      logic [127:0] l;
      logic [63:0] r, len, r2, t43, p, m, l2, a, b, in1, in2, inertia;
      u.length = 0;
      u.fault  = 1;
      u.angle  = c.angle;
      for (int i = 0; i < 3; i++) u.pos[i] = c.pos[i];
      if (c.cyc != 0) begin
         r = {33'd0, c.radius};
         l = {64'd0, birth_len} +
             ({64'd0, birth_len + 2 * r} * {97'd0, c.age}) / {97'd0, c.cyc};
         len = (l > 128'h7fff_ffff) ? 64'h7fff_ffff : l[63:0];
         u.length = len[30:0];
         r2  = fx_mul(r, r);
         t43 = (4 * r) / 3;
         p   = fx_mul(PI_Q, r2);
         m   = fx_mul(p, fx_add(len, t43));
         l2  = fx_mul(len, len);
         a   = fx_add(l2 / 12, r2 >> 2);
         in1 = fx_mul(len, a);
         b   = fx_add(fx_add((2 * r2) / 5, l2 >> 2), (3 * fx_mul(len, r)) >> 3);
         in2 = fx_mul(t43, b);
         inertia = fx_mul(p, fx_add(in1, in2));
         if (m != 0 && inertia != 0) begin
            u.fault = 0;
            for (int i = 0; i < 3; i++) u.pos[i] = euler_step(c.pos[i], c.frc[i], m);
            u.angle = euler_step(c.angle, c.torque, inertia);
         end
      end
      u.pos[2] = 0;
      return u;
   endfunction

   task automatic send_cell(cell_t c);
      int gap;
      gap = fast_src ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1;
      req_cell_age       <= c.age;
      req_cycle_duration <= c.cyc;
      req_radius         <= c.radius;
      req_pos_x          <= c.pos[0];
      req_pos_y          <= c.pos[1];
      req_pos_z          <= c.pos[2];
      req_force_x        <= c.frc[0];
      req_force_y        <= c.frc[1];
      req_force_z        <= c.frc[2];
      req_angle          <= c.angle;
      req_torque         <= c.torque;
      do @(posedge clock); while (!req_ready);
      pending_updates.push_back(predict_update(c));
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [30:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_TIME_STEP) step_dt = {33'd0, value};
      else if (idx == REG_INIT_LEN) birth_len = {33'd0, value};
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic cell_t make_cell();
      cell_t c;
      int kind;
      kind = $urandom_range(0, 99);
      c.cyc    = $urandom_range(65536, 65536 * 40);
      c.age    = $urandom_range(0, c.cyc);
      c.radius = $urandom_range(1000, 200000);
      for (int i = 0; i < 3; i++) begin
         c.pos[i] = $urandom_range(0, 1 << 29) - (1 << 28);
         c.frc[i] = $urandom();
      end
      c.angle  = $urandom_range(0, 1 << 20) - (1 << 19);
      c.torque = $urandom();
      if (kind < 15) begin
         c.age    = $urandom();
         c.cyc    = $urandom();
         c.radius = $urandom();
         for (int i = 0; i < 3; i++) c.pos[i] = $urandom();
         c.angle = $urandom();
      end else if (kind < 18) begin
         c.cyc = 0;
      end else if (kind < 21) begin
         c.radius = $urandom_range(0, 300);
      end
      return c;
   endfunction

   function automatic cell_t plain_cell(logic [30:0] age, logic [30:0] cyc, logic [30:0] r,
                                        logic [31:0] f, logic [31:0] pos, logic [31:0] tq);
      cell_t c;
      c.age = age;
      c.cyc = cyc;
      c.radius = r;
      for (int i = 0; i < 3; i++) begin
         c.pos[i] = pos;
         c.frc[i] = f;
      end
      c.pos[2] = 32'h1234_5678;
      c.angle  = pos;
      c.torque = tq;
      return c;
   endfunction

   task automatic test_extremes();
      send_cell(plain_cell(0, 65536, 32768, 32'h0001_0000, 0, 32'h0001_0000));
      send_cell(plain_cell(31'h7fff_ffff, 1, 32768, 32'h7fff_ffff, 32'h7fff_fff0, 32'h7fff_ffff));
      send_cell(plain_cell(65536, 131072, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0010,
                           32'h8000_0000));
      send_cell(plain_cell(31'h7fff_ffff, 31'h7fff_ffff, 65536, 32'hffff_ffff, 32'hffff_ffff,
                           32'h0000_0001));
      send_cell(plain_cell(65536, 0, 65536, 32'h0001_0000, 32'h0abc_0000, 32'h0001_0000));
      send_cell(plain_cell(65536, 131072, 0, 32'h0001_0000, 32'h0abc_0000, 32'h0001_0000));
      send_cell(plain_cell(65536, 131072, 1, 32'h7fff_ffff, 32'h0, 32'h8000_0000));
      send_cell(plain_cell(65536, 131072, 200, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff));
      send_cell(plain_cell(0, 31'h7fff_ffff, 0, 0, 32'h8000_0000, 0));
      wait_idle();
   endtask

   task automatic test_registers();
      write_reg(REG_UNUSED, 31'h7fff_ffff);
      write_reg(REG_LAST, 31'd5);
      write_reg(REG_TIME_STEP, 31'h7fff_ffff);
      write_reg(REG_INIT_LEN, 31'd0);
      send_cell(plain_cell(65536, 131072, 4096, 32'h7fff_ffff, 32'h7fff_0000, 32'h7fff_ffff));
      send_cell(plain_cell(65536, 131072, 4096, 32'h8000_0000, 32'h8001_0000, 32'h8000_0000));
      send_cell(plain_cell(0, 131072, 0, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff));
      wait_idle();
      write_reg(REG_TIME_STEP, 31'd0);
      write_reg(REG_INIT_LEN, 31'h7fff_ffff);
      send_cell(plain_cell(65536, 65536, 31'h7fff_ffff, 32'h7fff_ffff, 32'h1, 32'h8000_0000));
      send_cell(plain_cell(0, 65536, 65536, 32'h7fff_ffff, 32'h1, 32'h7fff_ffff));
      wait_idle();
      write_reg(REG_TIME_STEP, 31'd328);
      write_reg(REG_INIT_LEN, 31'd131072);
   endtask

   task automatic test_random(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            fast_src = ($urandom_range(0, 2) == 0);
            fast_snk = ($urandom_range(0, 2) == 0);
         end
         if (n % 300 == 299) begin
            wait_idle();
            write_reg(REG_TIME_STEP, ($urandom_range(0, 3) == 0) ? $urandom()
                                     : $urandom_range(0, 1 << 18));
            write_reg(REG_INIT_LEN, ($urandom_range(0, 3) == 0) ? $urandom()
                                    : $urandom_range(0, 1 << 19));
         end
         send_cell(make_cell());
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      fast_src = 1;
      hold_request = 1;
      for (int n = 0; n < 250; n++) send_cell(make_cell());
      fast_src = 0;
      wait_idle();
   endtask

   // result side: per-item wait, or one long hold when asked
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            w = LONG_HOLD;
         end else begin
            w = fast_snk ? 0 : $urandom_range(0, 18);
         end
         if (w > 0) begin
            rsp_ready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      update_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_updates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: len %h", rsp_new_length);
         end else begin
            e = pending_updates.pop_front();
            if (rsp_new_length !== e.length || rsp_new_pos_x !== e.pos[0] ||
                rsp_new_pos_y !== e.pos[1] || rsp_new_pos_z !== e.pos[2] ||
                rsp_new_angle !== e.angle || rsp_div_fault !== e.fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp len %h x %h y %h z %h ang %h flt %b / got %h %h %h %h %h %b",
                           e.length, e.pos[0], e.pos[1], e.pos[2], e.angle, e.fault,
                           rsp_new_length, rsp_new_pos_x, rsp_new_pos_y, rsp_new_pos_z,
                           rsp_new_angle, rsp_div_fault);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("capsule_euler_position_update verification failed");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_extremes();
      test_registers();
      test_random(1200);
      test_backpressure();
      mismatches += pending_updates.size();
      if (mismatches == 0)
         $display("capsule_euler_position_update verification clean");
      else
         $display("capsule_euler_position_update verification failed");
      $finish;
   end
endmodule
